// ===== design/rbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Relay bank pulse controller package
// Shared widths, action and register codes, reset values and the control
// and status structs that pass between the relay lanes, the save timer and
// the top level.
// ----------------------------------------------------------------------------
package rbpc_pkg;

    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 2;
    localparam int ACTIVE_W    = 3;
    localparam int ELAPSED_W   = 15;
    localparam int SINCE_W     = 16;
    localparam int MASK_W      = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [ACTION_W-1:0]    action_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Input item actions.
    localparam action_t ACT_TICK   = 2'd0;
    localparam action_t ACT_TOGGLE = 2'd1;
    localparam action_t ACT_SET    = 2'd2;
    localparam action_t ACT_PULSE  = 2'd3;

    // Configuration register indexes.
    localparam cfg_index_t REG_ACTIVE_RELAYS  = 2'd0;
    localparam cfg_index_t REG_PULSE_DURATION = 2'd1;
    localparam cfg_index_t REG_SAVE_INTERVAL  = 2'd2;

    // Configuration reset values.
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RELAYS_RST  = 3'd4;
    localparam logic [ELAPSED_W-1:0] PULSE_DURATION_RST = 15'd1000;
    localparam logic [SINCE_W-1:0]   SAVE_INTERVAL_RST  = 16'd1000;

    // Per-lane control for the item currently in the input register.
    typedef struct packed {
        logic                 step;
        logic                 tick;
        logic                 hit;
        action_t              action;
        logic                 set_value;
        logic                 active;
        logic [ELAPSED_W-1:0] pulse_duration;
    } lane_ctl_t;

    // Per-lane next state as seen after the current item.
    typedef struct packed {
        logic relay_on;
        logic running;
        logic pulse_end;
    } lane_stat_t;

    typedef struct packed {
        logic               step;
        logic               tick;
        logic               change;
        logic [SINCE_W-1:0] save_interval;
    } save_ctl_t;

    typedef struct packed {
        logic save_req;
        logic pending;
    } save_stat_t;

endpackage

// ===== design/rbpc_channels.sv =====
// ----------------------------------------------------------------------------
// Relay bank pulse controller channels
// Valid/ready interfaces for the command input, the result output and the
// configuration write port.
// ----------------------------------------------------------------------------
interface rbpc_in_if import rbpc_pkg::*; ();
    logic                valid;
    logic                ready;
    action_t             action;
    logic [INDEX_W-1:0]  relay_index;
    logic                set_value;

    modport source (output valid, output action, output relay_index, output set_value,
                    input ready);
    modport sink   (input valid, input action, input relay_index, input set_value,
                    output ready);
endinterface

interface rbpc_out_if import rbpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] relay_state_mask;
    logic [MASK_W-1:0] relay_drive_mask;
    logic [MASK_W-1:0] pulse_running_mask;
    logic              command_accepted;
    logic              save_request;

    modport source (output valid, output relay_state_mask, output relay_drive_mask,
                    output pulse_running_mask, output command_accepted,
                    output save_request, input ready);
    modport sink   (input valid, input relay_state_mask, input relay_drive_mask,
                    input pulse_running_mask, input command_accepted,
                    input save_request, output ready);
endinterface

interface rbpc_cfg_if import rbpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    cfg_index_t            reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/rbpc_relay_lane.sv =====
// ----------------------------------------------------------------------------
// Relay lane
// On/off state, pulse flag and saturating elapsed counter of one relay.
// ----------------------------------------------------------------------------
module rbpc_relay_lane import rbpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctl_t  ctl,
    output lane_stat_t stat
);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    logic                 on_reg, on_next;
    logic                 running_reg, running_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 pulse_end;

    always_comb
    begin
        on_next      = on_reg;
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        pulse_end    = 1'b0;
        if (ctl.tick)
        begin
            if (running_reg)
            begin
                if (elapsed_reg != ELAPSED_MAX)
                begin
                    elapsed_next = elapsed_reg + ELAPSED_W'(1);
                end
                // A pulse on an inactive relay keeps counting but cannot end.
                if (ctl.active && (elapsed_next >= ctl.pulse_duration))
                begin
                    on_next      = 1'b0;
                    running_next = 1'b0;
                    pulse_end    = 1'b1;
                end
            end
        end
        else if (ctl.hit)
        begin
            unique case (ctl.action)
                ACT_TOGGLE:
                begin
                    on_next = !on_reg;
                end
                ACT_SET:
                begin
                    on_next = ctl.set_value;
                end
                ACT_PULSE:
                begin
                    on_next      = 1'b1;
                    running_next = 1'b1;
                    elapsed_next = '0;
                end
                default:
                begin
                    on_next = on_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg      <= 1'b0;
            running_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (ctl.step)
        begin
            on_reg      <= on_next;
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign stat.relay_on  = on_next;
    assign stat.running   = running_next;
    assign stat.pulse_end = pulse_end;

endmodule

// ===== design/rbpc_save_timer.sv =====
// ----------------------------------------------------------------------------
// Save timer
// Tracks unsaved state and the time since the last save request.
// ----------------------------------------------------------------------------
module rbpc_save_timer import rbpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  save_ctl_t  ctl,
    output save_stat_t stat
);

    localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

    logic               pending_reg, pending_next;
    logic [SINCE_W-1:0] since_reg, since_next;
    logic               save_req;

    always_comb
    begin
        pending_next = pending_reg | ctl.change;
        since_next   = since_reg;
        save_req     = 1'b0;
        if (ctl.tick)
        begin
            if (since_reg != SINCE_MAX)
            begin
                since_next = since_reg + SINCE_W'(1);
            end
            if (pending_next && (since_next >= ctl.save_interval))
            begin
                save_req     = 1'b1;
                pending_next = 1'b0;
                since_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            since_reg   <= '0;
        end
        else if (ctl.step)
        begin
            pending_reg <= pending_next;
            since_reg   <= since_next;
        end
    end

    assign stat.save_req = save_req;
    assign stat.pending  = pending_reg;

endmodule

// ===== design/relay_bank_pulse_controller_core.sv =====
// Both stages advance together: a beat moves from the input to the result register.
// Throughput: one beat per cycle unless the output stalls. The input register
// feeds the result register through a single pass of lane and save-timer logic.
// Reset (rst_n low, asynchronous): all relays off, no pulses running, counters at
// zero, nothing pending, both stages empty, registers at 4 / 1000 / 1000.
// ----------------------------------------------------------------------------
// Relay bank pulse controller core
// A bank of relays driven by tick, toggle, set and pulse commands, with timed
// pulses and a rate-limited save request. One result beat per input beat.
// ----------------------------------------------------------------------------
module relay_bank_pulse_controller_core import rbpc_pkg::*;
#(
    parameter int RELAY_COUNT_MAX = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    rbpc_in_if.sink    in_ch,
    rbpc_out_if.source out_ch,
    rbpc_cfg_if.sink   cfg_ch
);

    // ------------------------------------------------------------------------
    // Configuration registers. The user must write them only while the block is
    // idle; the block does not enforce it. Lanes read them directly, no shadow copy.
    // ------------------------------------------------------------------------
    logic [ACTIVE_W-1:0]  active_relays_reg;
    logic [ELAPSED_W-1:0] pulse_duration_reg;
    logic [SINCE_W-1:0]   save_interval_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_relays_reg  <= ACTIVE_RELAYS_RST;
            pulse_duration_reg <= PULSE_DURATION_RST;
            save_interval_reg  <= SAVE_INTERVAL_RST;
        end
        else if (cfg_ch.valid)
        begin
            // A write to an index beyond the register list is accepted and dropped.
            unique case (cfg_ch.reg_index)
                REG_ACTIVE_RELAYS:  active_relays_reg  <= cfg_ch.wdata[ACTIVE_W-1:0];
                REG_PULSE_DURATION: pulse_duration_reg <= cfg_ch.wdata[ELAPSED_W-1:0];
                REG_SAVE_INTERVAL:  save_interval_reg  <= cfg_ch.wdata[SINCE_W-1:0];
                default:            active_relays_reg  <= active_relays_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input register. It refills in the same cycle that its beat moves on to
    // the result register, so a full result register that is being drained
    // does not stall the input side.
    // ------------------------------------------------------------------------
    logic               in_valid_reg;
    action_t            action_reg;
    logic [INDEX_W-1:0] relay_index_reg;
    logic               set_value_reg;
    logic               out_valid_reg;
    logic               stage_adv;

    assign stage_adv   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || stage_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            action_reg      <= in_ch.action;
            relay_index_reg <= in_ch.relay_index;
            set_value_reg   <= in_ch.set_value;
        end
    end

    // ------------------------------------------------------------------------
    // Relay lanes. Each lane holds its own state and computes what that state
    // becomes after the beat in the input register; state commits on stage_adv.
    // A command hits a lane only if the index matches and the relay is active,
    // which also covers an active count of zero or above the bank size.
    // ------------------------------------------------------------------------
    logic                       is_tick;
    logic [RELAY_COUNT_MAX-1:0] hit_vec;
    logic [RELAY_COUNT_MAX-1:0] active_vec;
    logic [RELAY_COUNT_MAX-1:0] on_next_vec;
    logic [RELAY_COUNT_MAX-1:0] run_next_vec;
    logic [RELAY_COUNT_MAX-1:0] end_vec;
    lane_ctl_t                  lane_ctl  [RELAY_COUNT_MAX];
    lane_stat_t                 lane_stat [RELAY_COUNT_MAX];

    assign is_tick = (action_reg == ACT_TICK);

    for (genvar i = 0; i < RELAY_COUNT_MAX; i++)
    begin : g_lane
        assign active_vec[i] = (32'(active_relays_reg) > i);
        assign hit_vec[i]    = !is_tick && active_vec[i] && (32'(relay_index_reg) == i);

        assign lane_ctl[i].step           = stage_adv;
        assign lane_ctl[i].tick           = is_tick;
        assign lane_ctl[i].hit            = hit_vec[i];
        assign lane_ctl[i].action         = action_reg;
        assign lane_ctl[i].set_value      = set_value_reg;
        assign lane_ctl[i].active         = active_vec[i];
        assign lane_ctl[i].pulse_duration = pulse_duration_reg;

        rbpc_relay_lane u_lane
        (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (lane_ctl[i]),
            .stat (lane_stat[i])
        );

        assign on_next_vec[i]  = lane_stat[i].relay_on;
        assign run_next_vec[i] = lane_stat[i].running;
        assign end_vec[i]      = lane_stat[i].pulse_end;
    end

    // ------------------------------------------------------------------------
    // Save timer. Any accepted command or any pulse that ends on this tick
    // marks the state unsaved.
    // ------------------------------------------------------------------------
    logic       accepted_next;
    save_ctl_t  save_ctl;
    save_stat_t save_stat;

    assign accepted_next          = |hit_vec;
    assign save_ctl.step          = stage_adv;
    assign save_ctl.tick          = is_tick;
    assign save_ctl.change        = accepted_next | (|end_vec);
    assign save_ctl.save_interval = save_interval_reg;

    rbpc_save_timer u_save
    (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (save_ctl),
        .stat (save_stat)
    );

    // ------------------------------------------------------------------------
    // Result masks cover the first four relays; bits past the bank size read 0.
    // ------------------------------------------------------------------------
    logic [MASK_W-1:0] state_mask_next;
    logic [MASK_W-1:0] drive_mask_next;
    logic [MASK_W-1:0] run_mask_next;

    for (genvar b = 0; b < MASK_W; b++)
    begin : g_mask
        if (b < RELAY_COUNT_MAX)
        begin : g_used
            assign state_mask_next[b] = on_next_vec[b];
            assign drive_mask_next[b] = on_next_vec[b] & active_vec[b];
            assign run_mask_next[b]   = run_next_vec[b];
        end
        else
        begin : g_unused
            assign state_mask_next[b] = 1'b0;
            assign drive_mask_next[b] = 1'b0;
            assign run_mask_next[b]   = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------------
    logic [MASK_W-1:0] state_mask_reg;
    logic [MASK_W-1:0] drive_mask_reg;
    logic [MASK_W-1:0] run_mask_reg;
    logic              accepted_reg;
    logic              save_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            state_mask_reg <= state_mask_next;
            drive_mask_reg <= drive_mask_next;
            run_mask_reg   <= run_mask_next;
            accepted_reg   <= accepted_next;
            save_req_reg   <= save_stat.save_req;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.relay_state_mask   = state_mask_reg;
    assign out_ch.relay_drive_mask   = drive_mask_reg;
    assign out_ch.pulse_running_mask = run_mask_reg;
    assign out_ch.command_accepted   = accepted_reg;
    assign out_ch.save_request       = save_req_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
`ifndef SYNTHESIS
    // Save requests only come from ticks, and ticks are never accepted commands.
    a_save_not_on_command: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.save_request && out_ch.command_accepted))
        else $error("save request reported together with an accepted command");

    // A relay is only driven if its stored state is on.
    a_drive_within_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.relay_drive_mask & ~out_ch.relay_state_mask) == '0))
        else $error("drive mask has a bit set that the state mask lacks");

    // An applied command always leaves the state marked unsaved.
    a_command_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_adv && accepted_next) |=> save_stat.pending)
        else $error("accepted command did not mark the state unsaved");
`endif

endmodule
